// ----- rtl/sts_pkg.sv -----
// shared types and constants of the script token scanner
package sts_pkg;

  localparam int OFF_W      = 20;
  localparam int LINE_W     = 20;
  localparam int INT_W      = 32;
  localparam int FRAC_W     = 30;
  localparam int FCNT_W     = 4;
  localparam int MAX_FRAC   = 9;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [3:0] {
    M_IDLE, M_MINUS, M_SLASH, M_LT, M_GT, M_EQ, M_TILDE, M_COMMENT,
    M_STR, M_STR_ESC, M_ZERO, M_HEX, M_DEC, M_FRAC, M_SYM
  } mode_t;

  typedef enum logic [3:0] {
    K_END, K_CHAR, K_INTDIV, K_LE, K_SHL, K_GE, K_SHR, K_EQ, K_NE,
    K_STRING, K_NUMBER, K_SYMBOL
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          ch;
    logic [LINE_W-1:0]   line;
    logic [OFF_W-1:0]    start;
    logic [OFF_W-1:0]    stop;
    logic [INT_W-1:0]    ival;
    logic [FRAC_W-1:0]   fdig;
    logic [FCNT_W-1:0]   fcnt;
  } tok_t;

  // everything one source byte produced: one or two tokens
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ----- rtl/sts_front.sv -----
// front end: scans one source byte per cycle while take is high and forms its tokens
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] c,
  output logic       wr,
  output entry_t     wr_data
);

  mode_t              mode, mode_next;
  logic [7:0]         lend, lend_next;
  logic [LINE_W-1:0]  line, line_next;
  logic [OFF_W-1:0]   off, off_next;
  logic [OFF_W-1:0]   tstart, tstart_next;
  logic [LINE_W-1:0]  tline, tline_next;
  logic [INT_W-1:0]   iacc, iacc_next;
  logic [FRAC_W-1:0]  facc, facc_next;
  logic [FCNT_W-1:0]  fcnt, fcnt_next;
  logic [7:0]         quote, quote_next;

  logic  c_num, c_letter, is_hex, c_blank, is_nl;
  logic [3:0] hval;
  logic  again, pair, is_two, t0v, fv;
  kind_t two_kind;
  logic [7:0] pch;
  tok_t  t0, ft;

  function automatic tok_t mk(kind_t k, logic [7:0] ch, logic [LINE_W-1:0] ln,
                              logic [OFF_W-1:0] s, logic [OFF_W-1:0] e,
                              logic [INT_W-1:0] iv, logic [FRAC_W-1:0] fd,
                              logic [FCNT_W-1:0] fc);
    tok_t t;
    t.kind = k; t.ch = ch; t.line = ln; t.start = s; t.stop = e;
    t.ival = iv; t.fdig = fd; t.fcnt = fc;
    return t;
  endfunction

  always_comb begin
    c_num    = (c >= "0") && (c <= "9");
    c_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    is_hex   = c_num || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    c_blank  = (c == " ") || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    is_nl    = (c == CH_LF) || (c == CH_CR);
    if (c_num) hval = c[3:0] - 4'd0;
    else hval = c[3:0] + 4'd9;
  end

  always_comb begin
    mode_next = mode; lend_next = lend; line_next = line;
    off_next = (off == '1) ? off : off + 1'b1;
    tstart_next = tstart; tline_next = tline; iacc_next = iacc;
    facc_next = facc; fcnt_next = fcnt; quote_next = quote;
    again = 1'b0; pair = 1'b0; is_two = 1'b0; two_kind = K_END; pch = 8'd0;
    t0v = 1'b0; fv = 1'b0;
    t0 = mk(K_END, 8'd0, tline, tstart, off, '0, '0, '0);
    ft = t0;

    unique case (mode)
      M_MINUS: begin
        if (c == "-") mode_next = M_COMMENT;
        else begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_CHAR, "-", tline, tstart, tstart + 1'b1, '0, '0, '0);
        end
      end
      M_SLASH: begin
        pair = 1'b1; pch = "/";
        if (c == "/") begin is_two = 1'b1; two_kind = K_INTDIV; end
      end
      M_LT: begin
        pair = 1'b1; pch = "<";
        if (c == "=") begin is_two = 1'b1; two_kind = K_LE; end
        else if (c == "<") begin is_two = 1'b1; two_kind = K_SHL; end
      end
      M_GT: begin
        pair = 1'b1; pch = ">";
        if (c == "=") begin is_two = 1'b1; two_kind = K_GE; end
        else if (c == ">") begin is_two = 1'b1; two_kind = K_SHR; end
      end
      M_EQ: begin
        pair = 1'b1; pch = "=";
        if (c == "=") begin is_two = 1'b1; two_kind = K_EQ; end
      end
      M_TILDE: begin
        pair = 1'b1; pch = "~";
        if (c == "=") begin is_two = 1'b1; two_kind = K_NE; end
      end
      M_COMMENT: begin
        if (is_nl || (c == CH_NUL)) again = 1'b1;
      end
      M_STR, M_STR_ESC: begin
        if (c == CH_NUL) begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_STRING, 8'd0, tline, tstart, off, '0, '0, '0);
        end else if (mode == M_STR_ESC) begin
          mode_next = M_STR;
        end else if (c == quote) begin
          t0v = 1'b1; mode_next = M_IDLE;
          t0 = mk(K_STRING, 8'd0, tline, tstart, off + 1'b1, '0, '0, '0);
        end else if (c == "\\") begin
          mode_next = M_STR_ESC;
        end
      end
      M_HEX: begin
        if (is_hex) iacc_next = {iacc[INT_W-5:0], hval};
        else begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_NUMBER, 8'd0, tline, tstart, off, iacc, facc, fcnt);
        end
      end
      M_ZERO, M_DEC: begin
        if ((mode == M_ZERO) && (c == "x")) mode_next = M_HEX;
        else if (c_num) begin
          mode_next = M_DEC;
          iacc_next = {iacc[INT_W-4:0], 3'b000} + {iacc[INT_W-2:0], 1'b0}
                      + {{(INT_W-4){1'b0}}, c[3:0]};
        end else if (c == ".") mode_next = M_FRAC;
        else begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_NUMBER, 8'd0, tline, tstart, off, iacc, facc, fcnt);
        end
      end
      M_FRAC: begin
        if (c_num) begin
          if (fcnt < FCNT_W'(MAX_FRAC)) begin
            facc_next = {facc[FRAC_W-4:0], 3'b000} + {facc[FRAC_W-2:0], 1'b0}
                        + {{(FRAC_W-4){1'b0}}, c[3:0]};
            fcnt_next = fcnt + 1'b1;
          end
        end else begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_NUMBER, 8'd0, tline, tstart, off, iacc, facc, fcnt);
        end
      end
      M_SYM: begin
        if (!(c_letter || c_num)) begin
          t0v = 1'b1; again = 1'b1;
          t0 = mk(K_SYMBOL, 8'd0, tline, tstart, off, '0, '0, '0);
        end
      end
      default: again = 1'b1;
    endcase

    if (pair) begin
      t0v = 1'b1;
      if (is_two) begin
        mode_next = M_IDLE;
        t0 = mk(two_kind, 8'd0, tline, tstart, off + 1'b1, '0, '0, '0);
      end else begin
        again = 1'b1;
        t0 = mk(K_CHAR, pch, tline, tstart, tstart + 1'b1, '0, '0, '0);
      end
    end

    // byte rescanned as the start of whatever follows
    if (again) begin
      mode_next = M_IDLE;
      if (is_nl) begin
        if ((lend != CH_NUL) && (c != lend)) lend_next = CH_NUL;
        else begin
          lend_next = c;
          line_next = (line == '1) ? line : line + 1'b1;
        end
      end else begin
        lend_next = CH_NUL;
        if (c == CH_NUL) begin
          fv = 1'b1;
          ft = mk(K_END, 8'd0, line, off, off, '0, '0, '0);
          line_next = LINE_W'(1); off_next = '0; tstart_next = '0;
          tline_next = LINE_W'(1); iacc_next = '0; facc_next = '0;
          fcnt_next = '0; quote_next = 8'd0;
        end else if (!c_blank) begin
          tstart_next = off; tline_next = line;
          iacc_next = '0; facc_next = '0; fcnt_next = '0;
          if (c == "-") mode_next = M_MINUS;
          else if (c == "/") mode_next = M_SLASH;
          else if (c == "<") mode_next = M_LT;
          else if (c == ">") mode_next = M_GT;
          else if (c == "=") mode_next = M_EQ;
          else if (c == "~") mode_next = M_TILDE;
          else if ((c == "\"") || (c == "'")) begin
            quote_next = c; mode_next = M_STR;
          end else if (c == "0") mode_next = M_ZERO;
          else if (c_num) begin
            iacc_next = {{(INT_W-4){1'b0}}, c[3:0]};
            mode_next = M_DEC;
          end else if (c_letter) mode_next = M_SYM;
          else begin
            fv = 1'b1;
            ft = mk(K_CHAR, c, line, off, off + 1'b1, '0, '0, '0);
          end
        end
      end
    end

    wr = take && (t0v || fv);
    wr_data.two = t0v && fv;
    wr_data.t0  = t0v ? t0 : ft;
    wr_data.t1  = ft;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; lend <= 8'd0; line <= LINE_W'(1); off <= '0;
      tstart <= '0; tline <= LINE_W'(1); iacc <= '0; facc <= '0;
      fcnt <= '0; quote <= 8'd0;
    end else if (take) begin
      mode <= mode_next; lend <= lend_next; line <= line_next; off <= off_next;
      tstart <= tstart_next; tline <= tline_next; iacc <= iacc_next;
      facc <= facc_next; fcnt <= fcnt_next; quote <= quote_next;
    end
  end

endmodule

// ----- rtl/sts_queue.sv -----
// short queue of scanned entries between front and back
module sts_queue import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  entry_t    wr_data,
  input  logic      rd,
  output entry_t    rd_data,
  output q_status_t status
);

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp, rp;
  logic [Q_CNT_W-1:0] cnt;
  logic               do_wr, do_rd;

  assign status.full  = (cnt == Q_CNT_W'(Q_DEPTH));
  assign status.valid = (cnt != '0);
  assign do_wr   = wr && !status.full;
  assign do_rd   = rd && status.valid;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + 1'b1;
      if (do_rd) rp <= rp + 1'b1;
      cnt <= cnt + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= Q_CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");
  a_no_wr_full: assert property (@(posedge clk) disable iff (rst)
    !(wr && status.full)) else $error("write into full queue");
  a_rd_drop: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (cnt == $past(cnt) - 1'b1)) else $error("read lost");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> (wp == rp)) else $error("pointers apart on empty queue");

endmodule

// ----- rtl/sts_back.sv -----
// back end: hands out the tokens of each entry one beat at a time
module sts_back import sts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   rd,
  input  logic   pop,
  output logic   empty,
  output tok_t   tok,
  output logic   last
);

  entry_t ent;
  logic   idx, ovalid, done;

  assign empty = !ovalid;
  assign last  = idx || !ent.two;
  assign tok   = idx ? ent.t1 : ent.t0;
  assign done  = pop && ovalid && last;
  assign rd    = head_valid && (!ovalid || done);

  always_ff @(posedge clk) begin
    if (rd) ent <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0; idx <= 1'b0;
    end else if (rd) begin
      ovalid <= 1'b1; idx <= 1'b0;
    end else if (done) begin
      ovalid <= 1'b0; idx <= 1'b0;
    end else if (pop && ovalid) begin
      idx <= 1'b1;
    end
  end

  a_idx_two: assert property (@(posedge clk) disable iff (rst)
    (ovalid && idx) |-> ent.two) else $error("second token of single entry");
  a_second: assert property (@(posedge clk) disable iff (rst)
    (pop && ovalid && !last) |=> (ovalid && idx)) else $error("second token skipped");
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    rd |-> head_valid) else $error("read from empty queue");

endmodule

// ----- rtl/script_token_scanner_core.sv -----
// top level of the script token scanner
// Source bytes go in on the push side: a beat is taken when push is high and
// full is low; byte 0 ends the source and the scanner starts a new one.
// Tokens come out on the pop side: while empty is low the oldest token sits
// on the result ports, and a beat is taken when pop is high. last marks the
// final token that one source byte produced; a byte gives zero, one or two.
// The scanner takes one byte per cycle while full is low; each byte's tokens are
// written into a four-entry queue at the edge that takes the byte, and then pass
// through the back end's token register to the result ports.
// Results leave at one token per cycle while pop is high, so bytes giving two
// tokens each drain at half rate once the queue fills.
// When the receiver stalls, the queue fills and full rises; no byte or token
// is lost. Reset (rst, synchronous) returns the scanner to line 1, offset 0,
// and empties the queue.
module script_token_scanner_core import sts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        source_byte,
  output logic              empty,
  input  logic              pop,
  output logic [3:0]        token_kind,
  output logic [7:0]        char_code,
  output logic [LINE_W-1:0] line_number,
  output logic [OFF_W-1:0]  start_offset,
  output logic [OFF_W-1:0]  end_offset,
  output logic [INT_W-1:0]  int_value,
  output logic [FRAC_W-1:0] frac_digits,
  output logic [FCNT_W-1:0] frac_count,
  output logic              last
);

  logic      take, wr, rd;
  entry_t    wr_data, head;
  q_status_t qs;
  tok_t      tok;

  assign full = qs.full;
  assign take = push && !qs.full;

  sts_front u_front (
    .clk(clk), .rst(rst), .take(take), .c(source_byte),
    .wr(wr), .wr_data(wr_data)
  );

  sts_queue u_queue (
    .clk(clk), .rst(rst), .wr(wr), .wr_data(wr_data),
    .rd(rd), .rd_data(head), .status(qs)
  );

  sts_back u_back (
    .clk(clk), .rst(rst), .head_valid(qs.valid), .head(head), .rd(rd),
    .pop(pop), .empty(empty), .tok(tok), .last(last)
  );

  assign token_kind   = tok.kind;
  assign char_code    = tok.ch;
  assign line_number  = tok.line;
  assign start_offset = tok.start;
  assign end_offset   = tok.stop;
  assign int_value    = tok.ival;
  assign frac_digits  = tok.fdig;
  assign frac_count   = tok.fcnt;

endmodule

// ----- bench/script_token_scanner_checker.sv -----
// token predictor and comparator for the script token scanner bench
`timescale 1ns / 1ps
module script_token_scanner_checker import sts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [7:0]        source_byte,
  input  logic              empty,
  input  logic              pop,
  input  logic [3:0]        token_kind,
  input  logic [7:0]        char_code,
  input  logic [LINE_W-1:0] line_number,
  input  logic [OFF_W-1:0]  start_offset,
  input  logic [OFF_W-1:0]  end_offset,
  input  logic [INT_W-1:0]  int_value,
  input  logic [FRAC_W-1:0] frac_digits,
  input  logic [FCNT_W-1:0] frac_count,
  input  logic              last,
  output int                fail_count,
  output int                tokens_pending
);

  typedef struct packed {
    tok_t t;
    logic lst;
  } exp_tok_t;

  exp_tok_t token_queue[$];

  mode_t             mode;
  logic [7:0]        eol_char;
  logic [LINE_W-1:0] cur_line;
  logic [OFF_W-1:0]  offset;
  logic [OFF_W-1:0]  tok_start;
  logic [LINE_W-1:0] tok_line;
  logic [INT_W-1:0]  ival;
  logic [FRAC_W-1:0] fval;
  logic [FCNT_W-1:0] fcnt;
  logic [7:0]        quote;
  int                nbeat;

  function automatic bit digit_chr(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_chr(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return digit_chr(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    if (digit_chr(c)) return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'(c - "A" + 10);
  endfunction

  task automatic clear_state();
    mode = M_IDLE; eol_char = 0; cur_line = 1; offset = 0;
    tok_start = 0; tok_line = 1; ival = 0; fval = 0; fcnt = 0; quote = 0;
  endtask

  task automatic add_token(kind_t k, logic [7:0] ch, logic [LINE_W-1:0] ln,
                           logic [OFF_W-1:0] s, logic [OFF_W-1:0] e, bit num);
    exp_tok_t x;
    x.t.kind = k; x.t.ch = ch; x.t.line = ln; x.t.start = s; x.t.stop = e;
    x.t.ival = num ? ival : '0;
    x.t.fdig = num ? fval : '0;
    x.t.fcnt = num ? fcnt : '0;
    x.lst = 0;
    token_queue.push_back(x);
    nbeat++;
  endtask

  // idle-state scan of one byte
  task automatic scan_fresh(logic [7:0] c, logic [OFF_W-1:0] pos);
    if (c == CH_LF || c == CH_CR) begin
      if (eol_char != 0 && c != eol_char) eol_char = 0;
      else begin
        eol_char = c;
        if (cur_line != '1) cur_line++;
      end
      return;
    end
    eol_char = 0;
    if (c == CH_NUL) begin
      add_token(K_END, 0, cur_line, pos, pos, 0);
      clear_state();
      return;
    end
    if (c == " " || c == CH_TAB || c == CH_VT || c == CH_FF) return;
    tok_start = pos; tok_line = cur_line; ival = 0; fval = 0; fcnt = 0;
    case (c)
      "-": mode = M_MINUS;
      "/": mode = M_SLASH;
      "<": mode = M_LT;
      ">": mode = M_GT;
      "=": mode = M_EQ;
      "~": mode = M_TILDE;
      "\"", "'": begin
        quote = c; mode = M_STR;
      end
      "0": mode = M_ZERO;
      default: begin
        if (digit_chr(c)) begin
          ival = INT_W'(c - "0"); mode = M_DEC;
        end else if (letter_chr(c)) mode = M_SYM;
        else add_token(K_CHAR, c, tok_line, tok_start, pos + 1'b1, 0);
      end
    endcase
  endtask

  task automatic predict_byte(logic [7:0] c);
    logic [OFF_W-1:0] pos;
    bit rescan;
    logic [7:0] pair;
    kind_t two;
    bit has_two;
    pos = offset; rescan = 0; pair = 0; two = K_END; has_two = 0; nbeat = 0;
    if (offset != '1) offset++;
    if (mode == M_ZERO && c != "x") mode = M_DEC;
    case (mode)
      M_MINUS: begin
        if (c == "-") mode = M_COMMENT;
        else begin
          add_token(K_CHAR, "-", tok_line, tok_start, tok_start + 1'b1, 0);
          rescan = 1;
        end
      end
      M_SLASH: begin
        pair = "/"; if (c == "/") begin two = K_INTDIV; has_two = 1; end
      end
      M_LT: begin
        pair = "<";
        if (c == "=") begin two = K_LE; has_two = 1; end
        else if (c == "<") begin two = K_SHL; has_two = 1; end
      end
      M_GT: begin
        pair = ">";
        if (c == "=") begin two = K_GE; has_two = 1; end
        else if (c == ">") begin two = K_SHR; has_two = 1; end
      end
      M_EQ: begin
        pair = "="; if (c == "=") begin two = K_EQ; has_two = 1; end
      end
      M_TILDE: begin
        pair = "~"; if (c == "=") begin two = K_NE; has_two = 1; end
      end
      M_COMMENT: if (c == CH_LF || c == CH_CR || c == CH_NUL) rescan = 1;
      M_STR, M_STR_ESC: begin
        if (c == CH_NUL) begin
          add_token(K_STRING, 0, tok_line, tok_start, pos, 0);
          rescan = 1;
        end else if (mode == M_STR_ESC) mode = M_STR;
        else if (c == quote) begin
          add_token(K_STRING, 0, tok_line, tok_start, pos + 1'b1, 0);
          mode = M_IDLE;
        end else if (c == "\\") mode = M_STR_ESC;
      end
      M_ZERO: mode = M_HEX;
      M_HEX: begin
        if (is_hex(c)) ival = (ival << 4) + hex_nibble(c);
        else begin
          add_token(K_NUMBER, 0, tok_line, tok_start, pos, 1);
          rescan = 1;
        end
      end
      M_DEC: begin
        if (digit_chr(c)) ival = ival * 10 + INT_W'(c - "0");
        else if (c == ".") mode = M_FRAC;
        else begin
          add_token(K_NUMBER, 0, tok_line, tok_start, pos, 1);
          rescan = 1;
        end
      end
      M_FRAC: begin
        if (digit_chr(c)) begin
          if (fcnt < MAX_FRAC) begin
            fval = fval * 10 + FRAC_W'(c - "0");
            fcnt++;
          end
        end else begin
          add_token(K_NUMBER, 0, tok_line, tok_start, pos, 1);
          rescan = 1;
        end
      end
      M_SYM: begin
        if (!(letter_chr(c) || digit_chr(c))) begin
          add_token(K_SYMBOL, 0, tok_line, tok_start, pos, 0);
          rescan = 1;
        end
      end
      default: rescan = 1;
    endcase
    if (pair != 0) begin
      if (has_two) begin
        add_token(two, 0, tok_line, tok_start, pos + 1'b1, 0);
        mode = M_IDLE;
      end else begin
        add_token(K_CHAR, pair, tok_line, tok_start, tok_start + 1'b1, 0);
        rescan = 1;
      end
    end
    if (rescan) begin
      mode = M_IDLE;
      scan_fresh(c, pos);
    end
    if (nbeat > 0) token_queue[$].lst = 1;
  endtask

  task automatic compare_token();
    exp_tok_t x;
    if (token_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected token beat: kind %0d start %0d", token_kind, start_offset);
      return;
    end
    x = token_queue.pop_front();
    if (token_kind !== x.t.kind || char_code !== x.t.ch || line_number !== x.t.line ||
        start_offset !== x.t.start || end_offset !== x.t.stop ||
        int_value !== x.t.ival || frac_digits !== x.t.fdig ||
        frac_count !== x.t.fcnt || last !== x.lst) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("token mismatch: expected kind %0d ch %0d line %0d %0d..%0d",
                 x.t.kind, x.t.ch, x.t.line, x.t.start, x.t.stop);
        $display("  int %0d frac %0d/%0d last %0b", x.t.ival, x.t.fdig, x.t.fcnt, x.lst);
        $display("                got kind %0d ch %0d line %0d %0d..%0d",
                 token_kind, char_code, line_number, start_offset, end_offset);
        $display("  int %0d frac %0d/%0d last %0b", int_value, frac_digits,
                 frac_count, last);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    tokens_pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      token_queue.delete();
      tokens_pending <= 0;
    end else begin
      if (pop && !empty) compare_token();
      if (push && !full) predict_byte(source_byte);
      tokens_pending <= token_queue.size();
    end
  end

endmodule

// ----- bench/script_token_scanner_core_test.sv -----
// stimulus and verdict for the script token scanner
`timescale 1ns / 1ps
module script_token_scanner_core_test;
  import sts_pkg::*;

  logic              clk = 0;
  logic              rst = 1;
  logic              push = 0;
  logic [7:0]        source_byte = 0;
  logic              pop = 0;
  logic              full, empty, last;
  logic [3:0]        token_kind;
  logic [7:0]        char_code;
  logic [LINE_W-1:0] line_number;
  logic [OFF_W-1:0]  start_offset, end_offset;
  logic [INT_W-1:0]  int_value;
  logic [FRAC_W-1:0] frac_digits;
  logic [FCNT_W-1:0] frac_count;
  int                fail_count, tokens_pending;
  int                cycle_count = 0;
  logic [7:0]        byte_list[$];

  localparam int CYCLE_LIMIT = 200000;

  always #5 clk = ~clk;

  script_token_scanner_core DUT (
    .clk, .rst, .push, .full, .source_byte, .empty, .pop, .token_kind,
    .char_code, .line_number, .start_offset, .end_offset, .int_value,
    .frac_digits, .frac_count, .last
  );

  script_token_scanner_checker checker_i (
    .clk, .rst, .push, .full, .source_byte, .empty, .pop, .token_kind,
    .char_code, .line_number, .start_offset, .end_offset, .int_value,
    .frac_digits, .frac_count, .last, .fail_count, .tokens_pending
  );

  // receiver stall pattern: phases of free flow, of light and of heavy stalling
  always @(posedge clk) begin
    if (cycle_count % 400 < 150) pop <= 1'b1;
    else if (cycle_count % 400 < 300) pop <= ($urandom_range(0, 3) != 0);
    else pop <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) byte_list.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_char();
    string alphabet = "abcxyzXF_09587.-/<>=~\"'\\ \t\n\r(),;+*#";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(1, 127));
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  // well-formed lexemes with random content, some noise bytes
  task automatic add_random_lexeme();
    string piece;
    case ($urandom_range(0, 11))
      0: add_text($sformatf("%0d", $urandom()));
      1: add_text($sformatf("0x%0h", $urandom()));
      2: add_text($sformatf("0x%0H", $urandom()));
      3: add_text($sformatf("%0d.%0d", $urandom_range(0, 999), $urandom()));
      4: begin
        piece = "ident_";
        add_text(piece);
        repeat ($urandom_range(0, 4)) byte_list.push_back(pick_char());
        add_text(" ");
      end
      5: begin
        byte_list.push_back($urandom_range(0, 1) ? "\"" : "'");
        repeat ($urandom_range(0, 6)) byte_list.push_back(pick_char());
        byte_list.push_back($urandom_range(0, 1) ? "\"" : "'");
      end
      6: begin
        add_text("-- c");
        repeat ($urandom_range(0, 5)) byte_list.push_back(pick_char());
        add_text("\n");
      end
      7: begin
        piece = "<=>=~===//<<>>";
        byte_list.push_back(piece[$urandom_range(0, piece.len() - 1)]);
        byte_list.push_back(piece[$urandom_range(0, piece.len() - 1)]);
      end
      8: add_text($urandom_range(0, 1) ? "\r\n" : "\n\r\n");
      9: if ($urandom_range(0, 5) == 0) byte_list.push_back(8'h00);
      default: repeat ($urandom_range(1, 3)) byte_list.push_back(pick_char());
    endcase
    if ($urandom_range(0, 2) == 0) add_text(" ");
  endtask

  task automatic send_byte(logic [7:0] b);
    push <= 1'b1;
    source_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_all();
    int burst;
    while (byte_list.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && byte_list.size() > 0) begin
        send_byte(byte_list.pop_front());
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    push <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: operators, comments, strings, numbers, line ends, repairs
    add_text("a=b==c~=d~e//f/g<=h<<i<j>=k>>l>m-n\r\n\n\r-- note\rx");
    add_text(" \t\x0b\x0c'es\\'c' \"q\" 0x 0xfF1 00 4294967297 5. 3.1234567891234");
    byte_list.push_back(8'hff);
    byte_list.push_back(8'h80);
    add_text("x1 \"open");
    byte_list.push_back(8'h00);
    add_text("-- open comment");
    byte_list.push_back(8'h00);
    add_text("abc");
    byte_list.push_back(8'h00);
    send_all();
    // hold off until the queue has fully drained
    while (tokens_pending != 0) @(posedge clk);
    while (byte_list.size() < 780) add_random_lexeme();
    byte_list.push_back(8'h00);
    send_all();
    while (tokens_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
